[design/q4k_pkg.sv]
// Shared types and constants for the Q4_K dequantize dot-product block.
package q4k_pkg;

   // Superblock geometry
   localparam int SUPERBLOCK_ELEMS = 256;
   localparam int BYTES_PER_BLOCK  = SUPERBLOCK_ELEMS / 2;
   localparam int POS_W            = $clog2(BYTES_PER_BLOCK);
   localparam int CHUNK_BYTES      = 32;
   localparam int CHUNK_LSB        = $clog2(CHUNK_BYTES);
   localparam int SUB_W            = POS_W - CHUNK_LSB + 1;

   // Field widths
   localparam int Q_W      = 4;
   localparam int SC_W     = 6;
   localparam int SCALE_W  = 16;
   localparam int ACT_W    = 16;
   localparam int SCALES_W = 96;
   localparam int ACC_W    = 64;

   // Arithmetic widths: q*sc, q*sc*d, m*dmin, weight (signed), weight*x (signed)
   localparam int QS_W  = Q_W + SC_W;
   localparam int QSD_W = QS_W + SCALE_W;
   localparam int MD_W  = SC_W + SCALE_W;
   localparam int W_W   = QSD_W + 1;
   localparam int P_W   = W_W + ACT_W;

   // Stream payload widths
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 64;

   // Saturation limits
   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Item kind codes (tuser on the request side)
   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_DATA   = 1'b1;

   // One classified data item: both nibbles with their sub-block scale/min
   typedef struct packed {
      logic [Q_W-1:0]     q_lo;
      logic [Q_W-1:0]     q_hi;
      logic [SC_W-1:0]    sc_lo;
      logic [SC_W-1:0]    mn_lo;
      logic [SC_W-1:0]    sc_hi;
      logic [SC_W-1:0]    mn_hi;
      logic [SCALE_W-1:0] d;
      logic [SCALE_W-1:0] dmin;
      logic [ACT_W-1:0]   x_lo;
      logic [ACT_W-1:0]   x_hi;
      logic               last;
   } item_type;

endpackage

[design/q4k_front.sv]
// Front end: accepts request transactions, holds the superblock header, classifies data bytes.
module q4k_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [q4k_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   input  logic                             queue_full,
   output logic                             push,
   output q4k_pkg::item_type                push_item
);

   localparam int BYTE_W  = 8;
   localparam int MID_OFS = 32;
   localparam int HI_OFS  = 64;

   // Sub-block j scale and min from the twelve packed bytes; returns {min, scale}
   function automatic logic [2*q4k_pkg::SC_W-1:0] sub_scale_min(
      input logic [q4k_pkg::SCALES_W-1:0] s,
      input logic [q4k_pkg::SUB_W-1:0]    j
   );
      logic [BYTE_W-1:0]        b_lo;
      logic [BYTE_W-1:0]        b_mid;
      logic [BYTE_W-1:0]        b_hi;
      logic [q4k_pkg::SC_W-1:0] sc;
      logic [q4k_pkg::SC_W-1:0] mn;
      b_lo  = s[{j[1:0], 3'b000} +: BYTE_W];
      b_mid = s[MID_OFS + {j[1:0], 3'b000} +: BYTE_W];
      b_hi  = s[HI_OFS + {j[1:0], 3'b000} +: BYTE_W];
      if (!j[q4k_pkg::SUB_W-1]) begin
         sc = b_lo[5:0];
         mn = b_mid[5:0];
      end else begin
         sc = {b_lo[7:6], b_hi[3:0]};
         mn = {b_mid[7:6], b_hi[7:4]};
      end
      return {mn, sc};
   endfunction

   logic [q4k_pkg::SCALES_W-1:0] scales_ff, scales_in;
   logic [q4k_pkg::SCALE_W-1:0]  d_ff, d_in;
   logic [q4k_pkg::SCALE_W-1:0]  dmin_ff, dmin_in;
   logic [q4k_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic                         accept;
   logic [q4k_pkg::SUB_W-1:0]    sub_lo;
   logic [q4k_pkg::SUB_W-1:0]    sub_hi;
   logic [2*q4k_pkg::SC_W-1:0]   smn_lo;
   logic [2*q4k_pkg::SC_W-1:0]   smn_hi;
   logic [7:0]                   quant;

   // Headers never need a queue slot, but one ready keeps the handshake simple
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && (req_tuser == q4k_pkg::KIND_DATA);

   // Header load and byte position
   always_comb begin
      scales_in = scales_ff;
      d_in      = d_ff;
      dmin_in   = dmin_ff;
      pos_in    = pos_ff;
      if (accept) begin
         if (req_tuser == q4k_pkg::KIND_HEADER) begin
            d_in      = req_tdata[15:0];
            dmin_in   = req_tdata[31:16];
            scales_in = req_tdata[127:32];
            pos_in    = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scales_ff <= '0;
         d_ff      <= '0;
         dmin_ff   <= '0;
         pos_ff    <= '0;
      end else begin
         scales_ff <= scales_in;
         d_ff      <= d_in;
         dmin_ff   <= dmin_in;
         pos_ff    <= pos_in;
      end
   end

   // Chunk c of the byte picks sub-blocks 2c (low nibble) and 2c+1 (high nibble)
   assign sub_lo = {pos_ff[q4k_pkg::POS_W-1:q4k_pkg::CHUNK_LSB], 1'b0};
   assign sub_hi = {pos_ff[q4k_pkg::POS_W-1:q4k_pkg::CHUNK_LSB], 1'b1};
   assign smn_lo = sub_scale_min(scales_ff, sub_lo);
   assign smn_hi = sub_scale_min(scales_ff, sub_hi);
   assign quant  = req_tdata[135:128];

   always_comb begin
      push_item.q_lo  = quant[3:0];
      push_item.q_hi  = quant[7:4];
      push_item.sc_lo = smn_lo[q4k_pkg::SC_W-1:0];
      push_item.mn_lo = smn_lo[2*q4k_pkg::SC_W-1:q4k_pkg::SC_W];
      push_item.sc_hi = smn_hi[q4k_pkg::SC_W-1:0];
      push_item.mn_hi = smn_hi[2*q4k_pkg::SC_W-1:q4k_pkg::SC_W];
      push_item.d     = d_ff;
      push_item.dmin  = dmin_ff;
      push_item.x_lo  = req_tdata[151:136];
      push_item.x_hi  = req_tdata[167:152];
      push_item.last  = req_tlast;
   end

endmodule

[design/q4k_queue.sv]
// Short queue of classified data items between the front end and the accumulator.
module q4k_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  q4k_pkg::item_type push_item,
   input  logic              pop,
   output q4k_pkg::item_type pop_item,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   q4k_pkg::item_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = mem_ff[rd_ptr_ff];

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (pop && empty) |-> 1'b0)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

endmodule

[design/q4k_back.sv]
// Back end: per-nibble weight multiply pipeline, saturating accumulator and result register.
module q4k_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             queue_empty,
   input  q4k_pkg::item_type                pop_item,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [q4k_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tuser
);

   logic                                adv;
   logic                                take;
   logic                                phase_ff, phase_in;

   // Stage 1: q*sc and m*dmin
   logic                                s1_valid_ff;
   logic [q4k_pkg::QS_W-1:0]            s1_qs_ff, s1_qs_in;
   logic [q4k_pkg::MD_W-1:0]            s1_md_ff, s1_md_in;
   logic [q4k_pkg::SCALE_W-1:0]         s1_d_ff, s1_d_in;
   logic signed [q4k_pkg::ACT_W-1:0]    s1_x_ff, s1_x_in;
   logic                                s1_last_ff, s1_last_in;
   logic [q4k_pkg::Q_W-1:0]             q_sel;
   logic [q4k_pkg::SC_W-1:0]            sc_sel;
   logic [q4k_pkg::SC_W-1:0]            mn_sel;

   // Stage 2: weight = q*sc*d - m*dmin
   logic                                s2_valid_ff;
   logic signed [q4k_pkg::W_W-1:0]      s2_w_ff, s2_w_in;
   logic signed [q4k_pkg::ACT_W-1:0]    s2_x_ff;
   logic                                s2_last_ff;
   logic [q4k_pkg::QSD_W-1:0]           qsd;

   // Stage 3: weight * activation
   logic                                s3_valid_ff;
   logic signed [q4k_pkg::P_W-1:0]      s3_p_ff, s3_p_in;
   logic                                s3_last_ff;

   // Accumulator and result register
   logic [q4k_pkg::ACC_W-1:0]           acc_ff, acc_in;
   logic                                sat_seen_ff, sat_seen_in;
   logic                                out_valid_ff, out_valid_in;
   logic [q4k_pkg::ACC_W-1:0]           out_data_ff, out_data_in;
   logic                                out_sat_ff, out_sat_in;
   logic signed [q4k_pkg::ACC_W-1:0]    p_ext;
   logic [q4k_pkg::ACC_W:0]             sum;
   logic                                ovf;
   logic [q4k_pkg::ACC_W-1:0]           acc_new;

   // Whole pipeline holds only while a finished row waits behind a full result register
   assign adv  = !(s3_valid_ff && s3_last_ff && out_valid_ff && !rsp_tready);
   assign take = adv && !queue_empty;
   assign pop  = take && phase_ff;

   // Low nibble on phase 0, high nibble on phase 1
   always_comb begin
      phase_in = take ? !phase_ff : phase_ff;
      q_sel    = phase_ff ? pop_item.q_hi  : pop_item.q_lo;
      sc_sel   = phase_ff ? pop_item.sc_hi : pop_item.sc_lo;
      mn_sel   = phase_ff ? pop_item.mn_hi : pop_item.mn_lo;
      s1_x_in  = $signed(phase_ff ? pop_item.x_hi : pop_item.x_lo);
      s1_qs_in = q4k_pkg::QS_W'(q_sel) * q4k_pkg::QS_W'(sc_sel);
      s1_md_in = q4k_pkg::MD_W'(mn_sel) * q4k_pkg::MD_W'(pop_item.dmin);
      s1_d_in  = pop_item.d;
      s1_last_in = phase_ff && pop_item.last;
   end

   // Weight and product
   always_comb begin
      qsd     = q4k_pkg::QSD_W'(s1_qs_ff) * q4k_pkg::QSD_W'(s1_d_ff);
      s2_w_in = $signed(q4k_pkg::W_W'(qsd) - q4k_pkg::W_W'(s1_md_ff));
      s3_p_in = s2_w_ff * s2_x_ff;
   end

   // Saturating add, then emit and clear on the last element of a row
   always_comb begin
      p_ext        = q4k_pkg::ACC_W'(s3_p_ff);
      sum          = {acc_ff[q4k_pkg::ACC_W-1], acc_ff} + {p_ext[q4k_pkg::ACC_W-1], p_ext};
      ovf          = sum[q4k_pkg::ACC_W] != sum[q4k_pkg::ACC_W-1];
      acc_new      = ovf ? (p_ext[q4k_pkg::ACC_W-1] ? q4k_pkg::ACC_MIN : q4k_pkg::ACC_MAX)
                         : sum[q4k_pkg::ACC_W-1:0];
      acc_in       = acc_ff;
      sat_seen_in  = sat_seen_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_sat_in   = out_sat_ff;
      if (adv && s3_valid_ff) begin
         if (s3_last_ff) begin
            acc_in       = '0;
            sat_seen_in  = 1'b0;
            out_valid_in = 1'b1;
            out_data_in  = acc_new;
            out_sat_in   = sat_seen_ff || ovf;
         end else begin
            acc_in      = acc_new;
            sat_seen_in = sat_seen_ff || ovf;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         sat_seen_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         sat_seen_ff  <= sat_seen_in;
         out_valid_ff <= out_valid_in;
         if (adv) begin
            s1_valid_ff <= take;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_qs_ff   <= s1_qs_in;
         s1_md_ff   <= s1_md_in;
         s1_d_ff    <= s1_d_in;
         s1_x_ff    <= s1_x_in;
         s1_last_ff <= s1_last_in;
         s2_w_ff    <= s2_w_in;
         s2_x_ff    <= s1_x_ff;
         s2_last_ff <= s1_last_ff;
         s3_p_ff    <= s3_p_in;
         s3_last_ff <= s2_last_ff;
      end
      out_data_ff <= out_data_in;
      out_sat_ff  <= out_sat_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_sat_ff;

   a_row_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && s3_valid_ff && s3_last_ff) |=> (acc_ff == '0 && !sat_seen_ff))
      else $error("accumulator not cleared after row end");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s3_valid_ff && s3_last_ff))
      else $error("result raised without a row-end element");

   a_row_end_on_high: assert property (@(posedge clock) disable iff (reset)
      (adv && take && !phase_ff) |=> !s1_last_ff)
      else $error("row end attached to a low-nibble element");

endmodule

[design/q4k_dequant_dot_product.sv]
// Top level of the Q4_K dequantize dot-product block.
//
//  channel  direction  ports                            contents
//  req      in         req_tvalid/tready/tdata/tuser/   header or data transaction
//                      tlast
//  rsp      out        rsp_tvalid/tready/tdata/tuser    row dot product and saturation flag
//
// A header transaction is absorbed by the front end and takes no accumulator time.
// A data transaction is split in the back end into its two nibbles, which share one
// saturating 64-bit adder at one element per cycle while the back end is not held,
// so the next data transaction is taken only after both nibbles of the one before;
// the queue absorbs short bursts at one per cycle. A row's last data transaction
// passes through the queue, stages 1 to 3 and the result register to reach rsp.
// Reset clears the header registers, byte position, queue, pipeline and accumulator.
// req_tready drops only when the queue is full; an rsp stall holds the back end only
// while a second finished row waits behind the result register.
module q4k_dequant_dot_product #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [15:0] block_scale, [31:16] block_min_scale, [95:32] scale_bytes_low,
   // [127:96] scale_bytes_high, [135:128] quant_byte, [151:136] act_low,
   // [167:152] act_high
   input  logic [q4k_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] kind
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [63:0] dot_product
   output logic [q4k_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] saturated
   output logic                             rsp_tuser
);

   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_empty;
   q4k_pkg::item_type push_item;
   q4k_pkg::item_type pop_item;

   // Accept and classify
   q4k_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // Decoupling queue
   q4k_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // Multiply, accumulate, deliver
   q4k_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_item    (pop_item),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
